>>> rtl/owdm_pkg.sv
// Shared widths, types and constants of the omni wheel drive mixer.
package owdm_pkg;

    localparam int CMD_W      = 16;
    localparam int DRIVE_W    = 17;
    localparam int SINE_W     = 16;
    localparam int TABLE_W    = 15;
    localparam int PROD_W     = 32;
    localparam int NUM_STAGES = 7;

    typedef logic signed [CMD_W-1:0]   cmd_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef logic signed [SINE_W-1:0]  sine_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // Signed sine and cosine of the two distinct wheel angles.
    typedef struct packed {
        sine_t sin_front_left;
        sine_t cos_front_left;
        sine_t sin_front_right;
        sine_t cos_front_right;
    } wheel_trig_t;

endpackage

>>> rtl/owdm_angle.sv
// Heading wrap, wheel angle formation and quadrant folding (pipeline stages one to four).
module owdm_angle import owdm_pkg::*; #(
    parameter int STEPS_PER_DEGREE = 8
) (
    input  logic                   aclk,
    input  logic [3:0]             stage_en,
    input  cmd_t                   heading,
    output logic [3:0][$clog2(90*STEPS_PER_DEGREE+1)-1:0] lookup_idx,
    output logic [3:0]             lookup_neg
);

    localparam int FULL_STEPS    = 360 * STEPS_PER_DEGREE;
    localparam int QUARTER_STEPS = 90 * STEPS_PER_DEGREE;
    localparam int ANG_W         = $clog2(FULL_STEPS);
    localparam int IDX_W         = $clog2(QUARTER_STEPS + 1);
    localparam int HEAD_OFFSET   =
        FULL_STEPS * ((32768 + FULL_STEPS - 1) / FULL_STEPS) - 32768;
    localparam int U_W           = CMD_W + 1;
    localparam int RECIP_W       = 24;
    localparam int RECIP_SHIFT   = 32;
    localparam int MUL_W         = U_W + RECIP_W;
    localparam int QT_W          = MUL_W - RECIP_SHIFT;
    localparam int REM_W         = ANG_W + 2;
    localparam longint RECIP_L   = 64'h1_0000_0000 / FULL_STEPS;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int OFFSET_A      = 120 * STEPS_PER_DEGREE;
    localparam int OFFSET_B      = 60 * STEPS_PER_DEGREE;

    // Stage one: biased heading and estimated quotient.
    logic [U_W-1:0]   u_reg, u_next;
    logic [QT_W-1:0]  quot_reg, quot_next;
    logic [MUL_W-1:0] recip_prod;

    always_comb begin
        u_next     = U_W'({~heading[CMD_W-1], heading[CMD_W-2:0]}) + U_W'(HEAD_OFFSET);
        recip_prod = MUL_W'(u_next) * MUL_W'(RECIP);
        quot_next  = recip_prod[MUL_W-1:RECIP_SHIFT];
    end

    // Stage two: remainder with a single correction step.
    logic [ANG_W-1:0] base_reg, base_next;
    logic [REM_W-1:0] rem;

    always_comb begin
        rem = REM_W'(u_reg) - REM_W'(REM_W'(quot_reg) * REM_W'(FULL_STEPS));
        if (rem >= REM_W'(FULL_STEPS)) begin
            base_next = ANG_W'(rem - REM_W'(FULL_STEPS));
        end else begin
            base_next = ANG_W'(rem);
        end
    end

    // Stage three: the two distinct wheel angles; the other two lie half a turn away.
    logic [1:0][ANG_W-1:0] ang_reg, ang_next;
    logic [1:0][ANG_W:0]   ang_sum;

    always_comb begin
        ang_sum[0] = (ANG_W+1)'(base_reg) + (ANG_W+1)'(OFFSET_A);
        ang_sum[1] = (ANG_W+1)'(base_reg) + (ANG_W+1)'(OFFSET_B);
        for (int i = 0; i < 2; i++) begin
            if (ang_sum[i] >= (ANG_W+1)'(FULL_STEPS)) begin
                ang_next[i] = ANG_W'(ang_sum[i] - (ANG_W+1)'(FULL_STEPS));
            end else begin
                ang_next[i] = ANG_W'(ang_sum[i]);
            end
        end
    end

    // Stage four: quadrant fold into a quarter-wave index and a sign.
    logic [3:0][IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]            neg_reg, neg_next;
    logic [1:0][1:0]       quad;
    logic [1:0][ANG_W-1:0] part;
    logic [1:0][IDX_W-1:0] frac;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            if (ang_reg[i] >= ANG_W'(3 * QUARTER_STEPS)) begin
                quad[i] = 2'd3;
                part[i] = ang_reg[i] - ANG_W'(3 * QUARTER_STEPS);
            end else if (ang_reg[i] >= ANG_W'(2 * QUARTER_STEPS)) begin
                quad[i] = 2'd2;
                part[i] = ang_reg[i] - ANG_W'(2 * QUARTER_STEPS);
            end else if (ang_reg[i] >= ANG_W'(QUARTER_STEPS)) begin
                quad[i] = 2'd1;
                part[i] = ang_reg[i] - ANG_W'(QUARTER_STEPS);
            end else begin
                quad[i] = 2'd0;
                part[i] = ang_reg[i];
            end
            frac[i] = IDX_W'(part[i]);
            // Sine: odd quadrants read the table backwards, the upper half is negative.
            idx_next[2*i]   = quad[i][0] ? IDX_W'(QUARTER_STEPS) - frac[i] : frac[i];
            neg_next[2*i]   = quad[i][1];
            // Cosine is the sine one quadrant further on.
            idx_next[2*i+1] = quad[i][0] ? frac[i] : IDX_W'(QUARTER_STEPS) - frac[i];
            neg_next[2*i+1] = quad[i][0] ^ quad[i][1];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            u_reg    <= u_next;
            quot_reg <= quot_next;
        end
        if (stage_en[1]) begin
            base_reg <= base_next;
        end
        if (stage_en[2]) begin
            ang_reg <= ang_next;
        end
        if (stage_en[3]) begin
            idx_reg <= idx_next;
            neg_reg <= neg_next;
        end
    end

    assign lookup_idx = idx_reg;
    assign lookup_neg = neg_reg;

endmodule

>>> rtl/owdm_quarter_table.sv
// Quarter-wave Q1.15 sine table with a registered, signed read (pipeline stage five).
module owdm_quarter_table import owdm_pkg::*; #(
    parameter int STEPS_PER_DEGREE = 8
) (
    input  logic                                       aclk,
    input  logic                                       load,
    input  logic [$clog2(90*STEPS_PER_DEGREE+1)-1:0]   idx,
    input  logic                                       neg,
    output sine_t                                      value
);

    localparam int QUARTER_STEPS = 90 * STEPS_PER_DEGREE;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_Q30    = 64'd536870912;

    // Sine of k quarter-steps by a Horner-form Taylor series in Q30 integers.
    function automatic logic [TABLE_W-1:0] table_entry(input logic [31:0] k);
        longint unsigned kk;
        longint unsigned xa;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned e;
        kk = 64'(k);
        xa = (kk * HALF_PI_Q30 + 64'(QUARTER_STEPS / 2)) / QUARTER_STEPS;
        x2 = (xa * xa + HALF_Q30) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((((x2 * t + HALF_Q30) >> 30) + 64'd78) / 156);
        t  = ONE_Q30 - ((((x2 * t + HALF_Q30) >> 30) + 64'd55) / 110);
        t  = ONE_Q30 - ((((x2 * t + HALF_Q30) >> 30) + 64'd36) / 72);
        t  = ONE_Q30 - ((((x2 * t + HALF_Q30) >> 30) + 64'd21) / 42);
        t  = ONE_Q30 - ((((x2 * t + HALF_Q30) >> 30) + 64'd10) / 20);
        t  = ONE_Q30 - ((((x2 * t + HALF_Q30) >> 30) + 64'd3) / 6);
        s  = (xa * t + HALF_Q30) >> 30;
        e  = (s * 64'd32767 + HALF_Q30) >> 30;
        if (e > 64'd32767) begin
            e = 64'd32767;
        end
        return TABLE_W'(e);
    endfunction

    logic [TABLE_W-1:0] rom [0:QUARTER_STEPS];

    for (genvar k = 0; k <= QUARTER_STEPS; k++) begin : g_rom
        assign rom[k] = table_entry(32'(k));
    end

    sine_t value_reg, value_next;
    sine_t magnitude;

    always_comb begin
        magnitude  = SINE_W'(rom[idx]);
        value_next = neg ? -magnitude : magnitude;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

>>> rtl/owdm_mix.sv
// Products, rounding and per-wheel sums (pipeline stages six and seven).
module owdm_mix import owdm_pkg::*; (
    input  logic        aclk,
    input  logic [1:0]  stage_en,
    input  cmd_t        x_command,
    input  cmd_t        y_command,
    input  wheel_trig_t trig,
    output drive_t      left_front_drive,
    output drive_t      right_front_drive,
    output drive_t      left_back_drive,
    output drive_t      right_back_drive
);

    // Round a Q15 product to nearest, ties towards plus infinity.
    function automatic drive_t round_q15(input prod_t p);
        prod_t b;
        b = p + 32'sd16384;
        return drive_t'(b[PROD_W-1:PROD_W-DRIVE_W]);
    endfunction

    function automatic drive_t add_drive(input drive_t a, input drive_t b);
        logic signed [DRIVE_W:0] s;
        s = (DRIVE_W+1)'(a) + (DRIVE_W+1)'(b);
        return drive_t'(s[DRIVE_W-1:0]);
    endfunction

    prod_t xc_a_reg, ys_a_reg, xc_b_reg, ys_b_reg;
    drive_t lf_reg, rf_reg, lb_reg, rb_reg;
    drive_t lf_next, rf_next, lb_next, rb_next;

    // The back wheels sit half a turn from the front ones, so they use the negated products;
    // negating before rounding keeps the tie direction of the original sum.
    always_comb begin
        lf_next = add_drive(round_q15(xc_a_reg), round_q15(ys_a_reg));
        rb_next = add_drive(round_q15(-xc_a_reg), round_q15(-ys_a_reg));
        rf_next = add_drive(round_q15(xc_b_reg), round_q15(ys_b_reg));
        lb_next = add_drive(round_q15(-xc_b_reg), round_q15(-ys_b_reg));
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            xc_a_reg <= PROD_W'(x_command) * PROD_W'(trig.cos_front_left);
            ys_a_reg <= PROD_W'(y_command) * PROD_W'(trig.sin_front_left);
            xc_b_reg <= PROD_W'(x_command) * PROD_W'(trig.cos_front_right);
            ys_b_reg <= PROD_W'(y_command) * PROD_W'(trig.sin_front_right);
        end
        if (stage_en[1]) begin
            lf_reg <= lf_next;
            rf_reg <= rf_next;
            lb_reg <= lb_next;
            rb_reg <= rb_next;
        end
    end

    assign left_front_drive  = lf_reg;
    assign right_front_drive = rf_reg;
    assign left_back_drive   = lb_reg;
    assign right_back_drive  = rb_reg;

endmodule

>>> rtl/omni_wheel_drive_mixer_unit.sv
// Top level of the four-wheel omni drive mixer: pipeline control and stage wiring.
//
// The mixer turns one signed X/Y drive command and a robot heading (in 1/STEPS_PER_DEGREE
// degree steps, any 16-bit value, wrapped to one turn) into drive values for four omni wheels
// mounted at +120, +60, -120 and -60 degrees: drive = x*cos(h+offset) + y*sin(h+offset),
// each product rounded to nearest from Q1.15 sine values. It takes one item every clock cycle
// while the output side is not stalled. The seven register stages are: heading bias and
// reciprocal quotient estimate, heading remainder, wheel angles, quadrant folding,
// quarter-wave table read, the four 16x16 multiplications, and rounding with the
// per-wheel sums in the output register. Each
// stage has its own valid bit and moves on when the stage after it is empty or moving, so
// empty slots are filled while a result waits and a stall neither drops nor repeats an item.
// Only the two front wheels need table reads (four reads of a table of 90*STEPS_PER_DEGREE+1
// constant entries); the back wheels use the same products negated. There is no internal
// state between items and no start-up pass: the block is ready straight out of reset.
module omni_wheel_drive_mixer_unit import owdm_pkg::*; #(
    parameter int STEPS_PER_DEGREE = 8
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  cmd_t   s_x_command,
    input  cmd_t   s_y_command,
    input  cmd_t   s_heading,
    output logic   m_valid,
    input  logic   m_ready,
    output drive_t m_left_front_drive,
    output drive_t m_right_front_drive,
    output drive_t m_left_back_drive,
    output drive_t m_right_back_drive
);

    localparam int IDX_W = $clog2(90 * STEPS_PER_DEGREE + 1);
    localparam int CMD_DELAY = 5;

    // Stage control: a stage may load when it is empty or when the stage after it loads.
    logic [NUM_STAGES:1] valid_reg, valid_next, stage_en;

    always_comb begin
        stage_en[NUM_STAGES] = !valid_reg[NUM_STAGES] || m_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[1] = stage_en[1] ? s_valid : valid_reg[1];
        for (int k = 2; k <= NUM_STAGES; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[1];
    assign m_valid = valid_reg[NUM_STAGES];

    // The commands wait alongside the angle and table stages until the multipliers need them.
    cmd_t x_pipe_reg [1:CMD_DELAY];
    cmd_t y_pipe_reg [1:CMD_DELAY];

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            x_pipe_reg[1] <= s_x_command;
            y_pipe_reg[1] <= s_y_command;
        end
        for (int k = 2; k <= CMD_DELAY; k++) begin
            if (stage_en[k]) begin
                x_pipe_reg[k] <= x_pipe_reg[k-1];
                y_pipe_reg[k] <= y_pipe_reg[k-1];
            end
        end
    end

    // Stages one to four: heading wrap and quarter-wave indices.
    logic [3:0][IDX_W-1:0] lookup_idx;
    logic [3:0]            lookup_neg;

    owdm_angle #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
    ) u_angle (
        .aclk       (aclk),
        .stage_en   (stage_en[4:1]),
        .heading    (s_heading),
        .lookup_idx (lookup_idx),
        .lookup_neg (lookup_neg)
    );

    // Stage five: four table reads, sine then cosine for each front wheel angle.
    wheel_trig_t trig;

    owdm_quarter_table #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
    ) u_sin_a (
        .aclk  (aclk),
        .load  (stage_en[5]),
        .idx   (lookup_idx[0]),
        .neg   (lookup_neg[0]),
        .value (trig.sin_front_left)
    );

    owdm_quarter_table #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
    ) u_cos_a (
        .aclk  (aclk),
        .load  (stage_en[5]),
        .idx   (lookup_idx[1]),
        .neg   (lookup_neg[1]),
        .value (trig.cos_front_left)
    );

    owdm_quarter_table #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
    ) u_sin_b (
        .aclk  (aclk),
        .load  (stage_en[5]),
        .idx   (lookup_idx[2]),
        .neg   (lookup_neg[2]),
        .value (trig.sin_front_right)
    );

    owdm_quarter_table #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
    ) u_cos_b (
        .aclk  (aclk),
        .load  (stage_en[5]),
        .idx   (lookup_idx[3]),
        .neg   (lookup_neg[3]),
        .value (trig.cos_front_right)
    );

    // Stages six and seven: products, rounding and sums into the output register.
    owdm_mix u_mix (
        .aclk              (aclk),
        .stage_en          (stage_en[7:6]),
        .x_command         (x_pipe_reg[CMD_DELAY]),
        .y_command         (y_pipe_reg[CMD_DELAY]),
        .trig              (trig),
        .left_front_drive  (m_left_front_drive),
        .right_front_drive (m_right_front_drive),
        .left_back_drive   (m_left_back_drive),
        .right_back_drive  (m_right_back_drive)
    );

endmodule

>>> rtl/owdm_checker.sv
// Port-level checks of the omni wheel drive mixer, bound to its top level.
module owdm_checker import owdm_pkg::*; (
    input logic   aclk,
    input logic   aresetn,
    input logic   s_valid,
    input logic   s_ready,
    input logic   m_valid,
    input logic   m_ready,
    input drive_t m_left_front_drive,
    input drive_t m_right_front_drive,
    input drive_t m_left_back_drive,
    input drive_t m_right_back_drive
);

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the output side ready every stage moves, so the input side must be ready too.
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output ready");

    // An accepted item reaches the output when the output side never stalls meanwhile.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("item lost in pipeline");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_front_drive)
        && $stable(m_right_front_drive) && $stable(m_left_back_drive)
        && $stable(m_right_back_drive))
        else $error("stalled result changed");

endmodule

bind omni_wheel_drive_mixer_unit owdm_checker u_owdm_checker (.*);

>>> tb/owdm_drive_checker.sv
// Checker for the omni wheel drive mixer: predicts each drive set and compares it on output.
`timescale 1ns / 1ps

module owdm_drive_checker import owdm_pkg::*; #(
    parameter int STEPS_PER_DEGREE = 8
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  logic   s_ready,
    input  cmd_t   s_x_command,
    input  cmd_t   s_y_command,
    input  cmd_t   s_heading,
    input  logic   m_valid,
    input  logic   m_ready,
    input  drive_t m_left_front_drive,
    input  drive_t m_right_front_drive,
    input  drive_t m_left_back_drive,
    input  drive_t m_right_back_drive,
    output int     fail_count,
    output int     pending,
    output int     drive_sets_checked
);

    localparam int QUARTER_STEPS = 90 * STEPS_PER_DEGREE;
    localparam int FULL_STEPS    = 360 * STEPS_PER_DEGREE;

    localparam int OFFSET_LEFT_FRONT_DEG  = 120;
    localparam int OFFSET_RIGHT_FRONT_DEG = 60;
    localparam int OFFSET_LEFT_BACK_DEG   = 240;
    localparam int OFFSET_RIGHT_BACK_DEG  = 300;

    localparam bit [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam bit [63:0] ONE_Q30     = 64'd1 << 30;
    localparam bit [63:0] HALF_Q30    = 64'd1 << 29;

    typedef struct packed {
        drive_t left_front;
        drive_t right_front;
        drive_t left_back;
        drive_t right_back;
    } drive_set_t;

    drive_set_t drive_q[$];
    int errors   = 0;
    int waiting  = 0;
    int compared = 0;

    assign fail_count         = errors;
    assign pending            = waiting;
    assign drive_sets_checked = compared;

    // Q1.15 sine of k quarter-table steps, from a fixed-point Taylor series in Q30.
    function automatic int quarter_sine(input int k);
        bit [63:0] xa, x2, t, m, s, e, n;
        xa = (64'(k) * HALF_PI_Q30 + 64'(QUARTER_STEPS / 2)) / 64'(QUARTER_STEPS);
        x2 = (xa * xa + HALF_Q30) >> 30;
        t  = ONE_Q30;
        // Divisors 156, 110, 72, 42, 20, 6 are (2j)(2j+1) for j from 6 down to 1.
        for (int j = 6; j >= 1; j--) begin
            n = 64'(2 * j * (2 * j + 1));
            m = (x2 * t + HALF_Q30) >> 30;
            t = ONE_Q30 - (m + n / 2) / n;
        end
        s = (xa * t + HALF_Q30) >> 30;
        e = (s * 64'd32767 + HALF_Q30) >> 30;
        if (e > 64'd32767) e = 64'd32767;
        return int'(e);
    endfunction

    function automatic int step_sine(input int a);
        int q, r;
        q = a / QUARTER_STEPS;
        r = a % QUARTER_STEPS;
        case (q & 3)
            0: return quarter_sine(r);
            1: return quarter_sine(QUARTER_STEPS - r);
            2: return -quarter_sine(r);
            default: return -quarter_sine(QUARTER_STEPS - r);
        endcase
    endfunction

    // Round a Q15 product to nearest, ties towards plus infinity.
    function automatic longint round_q15(input longint p);
        return (p + 64'sd16384) >>> 15;
    endfunction

    function automatic int wheel_drive(input int base, input int offset_deg,
                                       input cmd_t x, input cmd_t y);
        int angle;
        longint sin_v, cos_v;
        angle = (base + offset_deg * STEPS_PER_DEGREE) % FULL_STEPS;
        sin_v = step_sine(angle);
        cos_v = step_sine((angle + QUARTER_STEPS) % FULL_STEPS);
        return int'(round_q15(longint'(x) * cos_v) + round_q15(longint'(y) * sin_v));
    endfunction

    function automatic drive_set_t predict_drives(input cmd_t x, input cmd_t y, input cmd_t h);
        int base;
        drive_set_t d;
        base          = ((int'(h) % FULL_STEPS) + FULL_STEPS) % FULL_STEPS;
        d.left_front  = drive_t'(wheel_drive(base, OFFSET_LEFT_FRONT_DEG, x, y));
        d.right_front = drive_t'(wheel_drive(base, OFFSET_RIGHT_FRONT_DEG, x, y));
        d.left_back   = drive_t'(wheel_drive(base, OFFSET_LEFT_BACK_DEG, x, y));
        d.right_back  = drive_t'(wheel_drive(base, OFFSET_RIGHT_BACK_DEG, x, y));
        return d;
    endfunction

    task automatic check_field(input string wheel, input drive_t want, input drive_t got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s drive expected %0d, got %0d", $time, wheel, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        drive_set_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                drive_q.push_back(predict_drives(s_x_command, s_y_command, s_heading));
                waiting++;
            end
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected drive set, expected none, got %0d %0d %0d %0d",
                             $time, m_left_front_drive, m_right_front_drive,
                             m_left_back_drive, m_right_back_drive);
                end else begin
                    want = drive_q.pop_front();
                    waiting--;
                    compared++;
                    check_field("left front", want.left_front, m_left_front_drive);
                    check_field("right front", want.right_front, m_right_front_drive);
                    check_field("left back", want.left_back, m_left_back_drive);
                    check_field("right back", want.right_back, m_right_back_drive);
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the omni wheel drive mixer: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import owdm_pkg::*;

    localparam int STEPS_PER_DEGREE = 8;
    localparam int QUARTER_STEPS    = 90 * STEPS_PER_DEGREE;
    localparam int RANDOM_ITEMS     = 1750;
    localparam int NUM_PHASES       = 4;
    // Gaps and stalls are bounded by idle_len and the pipeline is seven deep, so
    // a quiet stretch of WATCHDOG_LIMIT can only mean the block has hung.
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 16;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    cmd_t   s_x_command = '0;
    cmd_t   s_y_command = '0;
    cmd_t   s_heading = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    drive_t m_left_front_drive;
    drive_t m_right_front_drive;
    drive_t m_left_back_drive;
    drive_t m_right_back_drive;

    int fail_count;
    int pending;
    int drive_sets_checked;
    int commands_sent = 0;
    int quiet_cycles = 0;

    // Idling controls: the stimulus switches these between phases so that
    // some stretches run at full rate on one side or on both.
    bit sender_gaps = 1'b1;
    bit receiver_stalls = 1'b1;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    omni_wheel_drive_mixer_unit #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
    ) u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_x_command         (s_x_command),
        .s_y_command         (s_y_command),
        .s_heading           (s_heading),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_left_front_drive  (m_left_front_drive),
        .m_right_front_drive (m_right_front_drive),
        .m_left_back_drive   (m_left_back_drive),
        .m_right_back_drive  (m_right_back_drive)
    );

    owdm_drive_checker #(
        .STEPS_PER_DEGREE (STEPS_PER_DEGREE)
    ) u_drive_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_x_command         (s_x_command),
        .s_y_command         (s_y_command),
        .s_heading           (s_heading),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_left_front_drive  (m_left_front_drive),
        .m_right_front_drive (m_right_front_drive),
        .m_left_back_drive   (m_left_back_drive),
        .m_right_back_drive  (m_right_back_drive),
        .fail_count          (fail_count),
        .pending             (pending),
        .drive_sets_checked  (drive_sets_checked)
    );

    // Length of one idle stretch: mostly none, often a short one, and
    // now and then a long one so that the pipeline fills or drains fully.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A drive command: mostly uniform over the whole 16-bit range, with a
    // share of extremes and small values around zero.
    function automatic cmd_t pick_command();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return cmd_t'(16'sh8000);
            1: return cmd_t'(16'sh7FFF);
            2: return cmd_t'($urandom_range(0, 6) - 3);
            default: return cmd_t'($urandom());
        endcase
    endfunction

    // A heading: any 16-bit pattern, within one or two turns either side of
    // zero, or on or beside a quadrant boundary where the table folds over.
    function automatic cmd_t pick_heading();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return cmd_t'($urandom());
        if (r < 8) return cmd_t'($urandom_range(0, 11519) - 5760);
        return cmd_t'($urandom_range(0, 15) * QUARTER_STEPS - 5760 + $urandom_range(0, 2) - 1);
    endfunction

    // Presents one command item and returns once it has been accepted. It is
    // called just after a rising edge, so valid either stays high for the
    // next item or drops for a gap, never both in one time step.
    task automatic send_command(input cmd_t x, input cmd_t y, input cmd_t h);
        int gap;
        gap = sender_gaps ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_x_command <= cmd_t'($urandom());
            s_y_command <= cmd_t'($urandom());
            s_heading <= cmd_t'($urandom());
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_x_command <= x;
        s_y_command <= y;
        s_heading <= h;
        do @(posedge aclk); while (!s_ready);
        commands_sent++;
    endtask

    // Result side: the receiver stalls for random stretches while stalls are
    // enabled and accepts every cycle otherwise.
    always @(posedge aclk) begin : receiver
        int stall_left;
        if (!receiver_stalls) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = idle_len();
        end
    end

    // The watchdog counts cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        // Directed commands: full-scale and zero values of both axes, every
        // sign combination, headings on each quadrant boundary, at either end
        // of a turn, outside one turn in both directions and at the two 16-bit
        // extremes, the 45 degree headings, and half-way products that exercise the
        // rounding tie.
        cmd_t directed_x[23] = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768,
                                 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                                 -32768, 32767, 1, -1, 12345, 16384, -16384};
        cmd_t directed_y[23] = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767,
                                 32767, -32768, -32768, 32767, 32767, -32768, 32767,
                                 -32768, 32767, 1, -1, -23456, -16384, 16384};
        cmd_t directed_h[23] = '{0, 0, 0, 0, 0, 0, 0, 720, 1440, 2160, 2879, 2880, -1,
                                 -32768, 32767, 360, 360, -2520, 719, 721, -2881,
                                 1080, 1000};
        int phase;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_x[i]) send_command(directed_x[i], directed_y[i], directed_h[i]);

        // Random commands in phases: idling on both sides, sender at full
        // rate, receiver never stalling, and both running flat out.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            sender_gaps = (phase == 0) || (phase == 2);
            receiver_stalls = (phase == 0) || (phase == 1);
            repeat (RANDOM_ITEMS / NUM_PHASES)
                send_command(pick_command(), pick_command(), pick_heading());
        end
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        s_valid <= 1'b0;

        // Wait for every predicted drive set, then let the pipeline run on
        // for a while so that any stray extra output is caught.
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d drive commands; %0d drive sets compared, %0d mismatches.",
                 commands_sent, drive_sets_checked, fail_count);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/owdm_pkg.sv
rtl/owdm_angle.sv
rtl/owdm_quarter_table.sv
rtl/owdm_mix.sv
rtl/omni_wheel_drive_mixer_unit.sv
rtl/owdm_checker.sv
tb/owdm_drive_checker.sv
tb/tb_top.sv
